/* src/assert_macros.svh */
// Assertion macros shared by the key debounce event FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kdef_pkg.sv */
// Shared types, constants and codes for the key debounce event FIFO.
`timescale 1ns / 1ps

package kdef_pkg;

    // Default sizes
    localparam int KEY_NUM_DEF    = 6;
    localparam int FIFO_DEPTH_DEF = 16;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int PINS_W     = 6;
    localparam int CODE_W     = 5;
    localparam int FLAG_W     = 6;
    localparam int ADDED_W    = 4;
    localparam int FILT_W     = 5;
    localparam int LONG_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int MASK_W     = 6;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_SCAN       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_MAIN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_SECOND = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 3'd4;

    // Register reset values
    localparam int                  RST_FILTER_INT = 5;
    localparam logic [FILT_W-1:0]   RST_FILTER     = FILT_W'(RST_FILTER_INT);
    localparam logic [LONG_W-1:0]   RST_LONG       = 16'd100;
    localparam logic [SPEED_W-1:0]  RST_SPEED      = 8'd50;
    localparam logic [MASK_W-1:0]   RST_REPEAT_EN  = 6'd48;
    localparam logic [MASK_W-1:0]   RST_ACTIVE_LOW = 6'd56;
    localparam logic [CNT_W-1:0]    RST_DEB_CNT    = CNT_W'(RST_FILTER_INT / 2);

    // Timing settings seen by every lane
    typedef struct packed {
        logic [FILT_W-1:0]  filter_time;
        logic [LONG_W-1:0]  long_time;
        logic [SPEED_W-1:0] repeat_speed;
    } t_cfg;

    // Events a lane raises on one scan tick
    typedef struct packed {
        logic key_down;
        logic key_up;
        logic key_long;
    } t_lane_ev;

endpackage

/* src/kdef_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kdef_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/kdef_lane.sv */
// One key lane: hysteresis debounce, long-press and auto-repeat timing.
`timescale 1ns / 1ps

module kdef_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_pressed,
    input  kdef_pkg::t_cfg     i_cfg,
    input  logic               i_repeat_en,
    output logic               o_state,
    output kdef_pkg::t_lane_ev o_ev
);

    logic [kdef_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_state, n_state;
    logic [kdef_pkg::LONG_W-1:0]  r_hold, n_hold;
    logic [kdef_pkg::SPEED_W-1:0] r_rep, n_rep;

    logic [kdef_pkg::CNT_W-1:0]   filt;
    logic [kdef_pkg::CNT_W-1:0]   filt2;
    logic [kdef_pkg::LONG_W-1:0]  hold_inc;
    logic [kdef_pkg::SPEED_W-1:0] rep_inc;
    kdef_pkg::t_lane_ev           ev;

    assign filt     = {1'b0, i_cfg.filter_time};
    assign filt2    = {i_cfg.filter_time, 1'b0};
    assign hold_inc = r_hold + 16'd1;
    assign rep_inc  = r_rep + 8'd1;

    // Next lane state for one scan tick
    always_comb begin
        n_cnt   = r_cnt;
        n_state = r_state;
        n_hold  = r_hold;
        n_rep   = r_rep;
        ev      = '0;
        if (i_pressed) begin
            if (r_cnt < filt) begin
                n_cnt = filt;
            end else if (r_cnt < filt2) begin
                n_cnt = r_cnt + 6'd1;
            end else begin
                if (!r_state) begin
                    n_state     = 1'b1;
                    ev.key_down = 1'b1;
                end
                if (i_cfg.long_time != '0) begin
                    if (r_hold < i_cfg.long_time) begin
                        n_hold = hold_inc;
                        if (hold_inc == i_cfg.long_time) begin
                            ev.key_long = 1'b1;
                        end
                    end else if ((i_cfg.repeat_speed != '0) && i_repeat_en) begin
                        if (rep_inc >= i_cfg.repeat_speed) begin
                            n_rep       = '0;
                            ev.key_long = 1'b1;
                        end else begin
                            n_rep = rep_inc;
                        end
                    end
                end
            end
        end else begin
            if (r_cnt > filt) begin
                n_cnt = filt;
            end else if (r_cnt != '0) begin
                n_cnt = r_cnt - 6'd1;
            end else if (r_state) begin
                n_state   = 1'b0;
                ev.key_up = 1'b1;
            end
            n_hold = '0;
            n_rep  = '0;
        end
    end

    // Advance on a scan tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= kdef_pkg::RST_DEB_CNT;
            r_state <= 1'b0;
            r_hold  <= '0;
            r_rep   <= '0;
        end else if (i_tick) begin
            r_cnt   <= n_cnt;
            r_state <= n_state;
            r_hold  <= n_hold;
            r_rep   <= n_rep;
        end
    end

    assign o_state = r_state;
    assign o_ev    = ev;

endmodule

/* src/kdef_merge.sv */
// Merge stage: collects lane events and hands out their codes in key order.
`timescale 1ns / 1ps

module kdef_merge #(
    parameter int KEY_NUM = kdef_pkg::KEY_NUM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  kdef_pkg::t_lane_ev            i_ev [KEY_NUM],
    input  logic                          i_take,
    output logic                          o_push,
    output logic [kdef_pkg::CODE_W-1:0]   o_code,
    output logic [kdef_pkg::ADDED_W-1:0]  o_added
);

    localparam int NSLOT = 2 * KEY_NUM;
    localparam int SEL_W = $clog2(NSLOT);

    logic [NSLOT-1:0]              r_pend, n_pend;
    logic [kdef_pkg::CODE_W-1:0]   r_code [NSLOT];
    logic [kdef_pkg::CODE_W-1:0]   n_code [NSLOT];
    logic [kdef_pkg::ADDED_W-1:0]  r_added, n_added;
    logic [SEL_W-1:0]              sel;

    // Slot 2i carries press or release of key i, slot 2i+1 its long/repeat
    always_comb begin
        n_added = '0;
        for (int i = 0; i < KEY_NUM; i++) begin
            n_pend[2*i]   = i_ev[i].key_down | i_ev[i].key_up;
            n_code[2*i]   = i_ev[i].key_up ? kdef_pkg::CODE_W'(3 * i + 2)
                                           : kdef_pkg::CODE_W'(3 * i + 1);
            n_pend[2*i+1] = i_ev[i].key_long;
            n_code[2*i+1] = kdef_pkg::CODE_W'(3 * i + 3);
        end
        for (int j = 0; j < NSLOT; j++) begin
            n_added = n_added + kdef_pkg::ADDED_W'(n_pend[j]);
        end
    end

    // Pick the lowest pending slot
    always_comb begin
        sel = '0;
        for (int j = NSLOT - 1; j >= 0; j--) begin
            if (r_pend[j]) begin
                sel = SEL_W'(j);
            end
        end
    end

    // Load on a scan tick, drop each slot as it is pushed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load) begin
            r_pend <= n_pend;
        end else if (i_take && (r_pend != '0)) begin
            r_pend[sel] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code  <= n_code;
            r_added <= n_added;
        end
    end

    assign o_push  = (r_pend != '0);
    assign o_code  = r_code[sel];
    assign o_added = r_added;

endmodule

/* src/key_debounce_event_fifo_core.sv */
// Top level: key debounce lanes, event merge, ring FIFO and its two readers.
//
// Usage. Items come in on the input channel (i_in_valid / o_in_stall) with
// i_action and i_key_pins; each gives exactly one result on the output
// channel (o_out_valid / i_out_stall): o_key_code, o_pressed_flags and
// o_events_added. Timing registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write them only while the block
// is idle, as the block itself does not enforce it. A clear, or a pop on an
// empty reader, gives its result in the cycle after the beat is taken; a
// pop that finds a code passes the registered read of the event RAM and the
// read state before its result is registered. A scan tick updates all key
// lanes at once, then pushes its codes one per cycle through the single RAM
// write port, then registers its result. One item is in work at a time.
// Reset clears the lanes, all three pointers and the registers to their
// default values; the event RAM needs no clearing, since no entry is read
// before it is written. A stalled result holds in the output register, and
// no new beat is taken until it leaves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_debounce_event_fifo_core #(
    parameter int KEY_NUM    = kdef_pkg::KEY_NUM_DEF,
    parameter int FIFO_DEPTH = kdef_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [kdef_pkg::ACTION_W-1:0]     i_action,
    input  logic [kdef_pkg::PINS_W-1:0]       i_key_pins,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [kdef_pkg::CODE_W-1:0]       o_key_code,
    output logic [kdef_pkg::FLAG_W-1:0]       o_pressed_flags,
    output logic [kdef_pkg::ADDED_W-1:0]      o_events_added,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [kdef_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kdef_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    // Configuration registers
    logic [kdef_pkg::FILT_W-1:0]  r_filter;
    logic [kdef_pkg::LONG_W-1:0]  r_long;
    logic [kdef_pkg::SPEED_W-1:0] r_speed;
    logic [kdef_pkg::MASK_W-1:0]  r_repeat_en;
    logic [kdef_pkg::MASK_W-1:0]  r_active_low;
    kdef_pkg::t_cfg               cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter     <= kdef_pkg::RST_FILTER;
            r_long       <= kdef_pkg::RST_LONG;
            r_speed      <= kdef_pkg::RST_SPEED;
            r_repeat_en  <= kdef_pkg::RST_REPEAT_EN;
            r_active_low <= kdef_pkg::RST_ACTIVE_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kdef_pkg::REG_FILTER:     r_filter     <= i_cfg_data[kdef_pkg::FILT_W-1:0];
                kdef_pkg::REG_LONG:       r_long       <= i_cfg_data[kdef_pkg::LONG_W-1:0];
                kdef_pkg::REG_SPEED:      r_speed      <= i_cfg_data[kdef_pkg::SPEED_W-1:0];
                kdef_pkg::REG_REPEAT_EN:  r_repeat_en  <= i_cfg_data[kdef_pkg::MASK_W-1:0];
                kdef_pkg::REG_ACTIVE_LOW: r_active_low <= i_cfg_data[kdef_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.filter_time  = r_filter;
    assign cfg.long_time    = r_long;
    assign cfg.repeat_speed = r_speed;

    // Control and pointer registers
    logic [1:0]                         r_state, n_state;
    logic [PTR_W-1:0]                   r_wp, n_wp;
    logic [PTR_W-1:0]                   r_rp_main, n_rp_main;
    logic [PTR_W-1:0]                   r_rp_second, n_rp_second;
    logic                               r_out_valid, n_out_valid;
    logic [kdef_pkg::CODE_W-1:0]        r_key_code, n_key_code;
    logic [kdef_pkg::FLAG_W-1:0]        r_flags, n_flags;
    logic [kdef_pkg::ADDED_W-1:0]       r_added, n_added;

    logic                               in_accept;
    logic                               scan_tick;
    logic                               merge_push;
    logic [kdef_pkg::CODE_W-1:0]        merge_code;
    logic [kdef_pkg::ADDED_W-1:0]       merge_added;
    logic                               ram_we;
    logic                               ram_re;
    logic [PTR_W-1:0]                   ram_raddr;
    logic [kdef_pkg::CODE_W-1:0]        ram_rdata;
    logic [KEY_NUM-1:0]                 lane_state;
    kdef_pkg::t_lane_ev                 lane_ev [KEY_NUM];
    logic [kdef_pkg::FLAG_W-1:0]        pressed_now;

    assign o_in_stall = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign scan_tick  = in_accept && (i_action == kdef_pkg::ACT_SCAN);

    // Key lanes
    for (genvar k = 0; k < KEY_NUM; k++) begin : g_lane
        kdef_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tick      (scan_tick),
            .i_pressed   (i_key_pins[k] ^ r_active_low[k]),
            .i_cfg       (cfg),
            .i_repeat_en (r_repeat_en[k]),
            .o_state     (lane_state[k]),
            .o_ev        (lane_ev[k])
        );
    end

    always_comb begin
        pressed_now = '0;
        for (int k = 0; k < KEY_NUM; k++) begin
            pressed_now[k] = lane_state[k];
        end
    end

    // Merge lane events in key order
    kdef_merge #(
        .KEY_NUM (KEY_NUM)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (scan_tick),
        .i_ev    (lane_ev),
        .i_take  (r_state == ST_SCAN),
        .o_push  (merge_push),
        .o_code  (merge_code),
        .o_added (merge_added)
    );

    // Event ring
    assign ram_we    = (r_state == ST_SCAN) && merge_push;
    assign ram_raddr = (i_action == kdef_pkg::ACT_POP_SECOND) ? r_rp_second : r_rp_main;
    assign ram_re    = in_accept && (ram_raddr != r_wp)
                       && ((i_action == kdef_pkg::ACT_POP_MAIN)
                           || (i_action == kdef_pkg::ACT_POP_SECOND));

    kdef_ram #(
        .WIDTH (kdef_pkg::CODE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (merge_code),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp_main   = r_rp_main;
        n_rp_second = r_rp_second;
        n_out_valid = r_out_valid && i_out_stall;
        n_key_code  = r_key_code;
        n_flags     = r_flags;
        n_added     = r_added;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_key_code = '0;
                    n_added    = '0;
                    n_flags    = pressed_now;
                    unique case (i_action) inside
                        kdef_pkg::ACT_SCAN: begin
                            n_state = ST_SCAN;
                        end
                        kdef_pkg::ACT_POP_MAIN, kdef_pkg::ACT_POP_SECOND: begin
                            if (ram_re) begin
                                n_state = ST_READ;
                                if (i_action == kdef_pkg::ACT_POP_MAIN) begin
                                    n_rp_main = (r_rp_main == LAST_PTR) ? '0
                                                : r_rp_main + PTR_W'(1);
                                end else begin
                                    n_rp_second = (r_rp_second == LAST_PTR) ? '0
                                                  : r_rp_second + PTR_W'(1);
                                end
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        kdef_pkg::ACT_CLEAR: begin
                            n_rp_main   = r_wp;
                            n_out_valid = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (merge_push) begin
                    n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
                end else begin
                    n_key_code  = '0;
                    n_added     = merge_added;
                    n_flags     = pressed_now;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_READ: begin
                n_key_code  = ram_rdata;
                n_added     = '0;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp_main   <= '0;
            r_rp_second <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp_main   <= n_rp_main;
            r_rp_second <= n_rp_second;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_key_code <= n_key_code;
        r_flags    <= n_flags;
        r_added    <= n_added;
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_code      = r_key_code;
    assign o_pressed_flags = r_flags;
    assign o_events_added  = r_added;

    // Checks
    `KD_ASSERT_NEXT(a_scan_starts, scan_tick, r_state == ST_SCAN, "scan tick did not start pushes")
    `KD_ASSERT_NEXT(a_scan_ends, (r_state == ST_SCAN) && !merge_push,
                    o_out_valid && (r_state == ST_IDLE), "scan result missing")
    `KD_ASSERT_NEXT(a_read_result, r_state == ST_READ, o_out_valid, "pop result missing")
    `KD_ASSERT_NOW(a_busy_no_result, r_state != ST_IDLE, !o_out_valid, "result pending during work")
    `KD_ASSERT_NOW(a_scan_no_code, o_out_valid && (o_events_added != '0),
                   o_key_code == '0, "scan result carries a code")

endmodule

/* tb/key_debounce_event_fifo_core_tb.sv */
// Self-checking bench for the key debounce event FIFO, scored against a lane model.
`timescale 1ns / 1ps

module key_debounce_event_fifo_core_tb;
    import kdef_pkg::*;

    localparam int KEYS      = KEY_NUM_DEF;
    localparam int DEPTH     = FIFO_DEPTH_DEF;
    localparam int IDLE_PCT  = 16;
    localparam int TOGGLE_PCT = 2;
    localparam int DRAIN_GAP = 16;
    localparam int PHASES    = 8;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [FLAG_W-1:0]  flags;
        logic [ADDED_W-1:0] added;
    } t_key_outcome;

    // Lane and ring model, plus the queue of outcomes still owed by the block
    class key_event_scoreboard;
        logic [FILT_W-1:0]  filter_time;
        logic [LONG_W-1:0]  long_time;
        logic [SPEED_W-1:0] repeat_speed;
        logic [MASK_W-1:0]  repeat_en;
        logic [MASK_W-1:0]  active_low;

        logic [CNT_W-1:0]   deb_cnt  [KEYS];
        bit                 is_down  [KEYS];
        logic [LONG_W-1:0]  hold_cnt [KEYS];
        logic [SPEED_W-1:0] rep_cnt  [KEYS];
        logic [CODE_W-1:0]  ring     [DEPTH];
        int                 wr_ptr;
        int                 main_ptr;
        int                 second_ptr;

        t_key_outcome       outcomes_due[$];
        int                 errors;
        int                 beats;

        function new();
            filter_time  = RST_FILTER;
            long_time    = RST_LONG;
            repeat_speed = RST_SPEED;
            repeat_en    = RST_REPEAT_EN;
            active_low   = RST_ACTIVE_LOW;
            for (int k = 0; k < KEYS; k++) begin
                deb_cnt[k]  = RST_DEB_CNT;
                is_down[k]  = 1'b0;
                hold_cnt[k] = '0;
                rep_cnt[k]  = '0;
            end
            for (int e = 0; e < DEPTH; e++) ring[e] = '0;
            wr_ptr     = 0;
            main_ptr   = 0;
            second_ptr = 0;
            errors     = 0;
            beats      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FILTER:     filter_time  = data[FILT_W-1:0];
                REG_LONG:       long_time    = data[LONG_W-1:0];
                REG_SPEED:      repeat_speed = data[SPEED_W-1:0];
                REG_REPEAT_EN:  repeat_en    = data[MASK_W-1:0];
                REG_ACTIVE_LOW: active_low   = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Write without any overrun check; a lapped reader loses its unread codes
        function void push_code(int code);
            ring[wr_ptr] = CODE_W'(code);
            wr_ptr = (wr_ptr + 1) % DEPTH;
        endfunction

        function logic [CODE_W-1:0] pop_event(bit second);
            int                rp;
            logic [CODE_W-1:0] v;
            rp = second ? second_ptr : main_ptr;
            if (rp == wr_ptr) return '0;
            v  = ring[rp];
            rp = (rp + 1) % DEPTH;
            if (second) second_ptr = rp;
            else main_ptr = rp;
            return v;
        endfunction

        // Advance one key by one scan tick; return the number of codes it pushed
        function int scan_key_lane(int k, bit down);
            int          n;
            int unsigned f;
            n = 0;
            f = filter_time;
            if (down) begin
                if (deb_cnt[k] < f) begin
                    deb_cnt[k] = CNT_W'(f);
                end else if (deb_cnt[k] < 2 * f) begin
                    deb_cnt[k] = deb_cnt[k] + 1'b1;
                end else begin
                    if (!is_down[k]) begin
                        is_down[k] = 1'b1;
                        push_code(3 * k + 1);
                        n++;
                    end
                    if (long_time != 0) begin
                        if (hold_cnt[k] < long_time) begin
                            hold_cnt[k] = hold_cnt[k] + 1'b1;
                            if (hold_cnt[k] == long_time) begin
                                push_code(3 * k + 3);
                                n++;
                            end
                        end else if (repeat_speed != 0 && repeat_en[k]) begin
                            rep_cnt[k] = rep_cnt[k] + 1'b1;
                            if (rep_cnt[k] >= repeat_speed) begin
                                rep_cnt[k] = '0;
                                push_code(3 * k + 3);
                                n++;
                            end
                        end
                    end
                end
            end else begin
                if (deb_cnt[k] > f) begin
                    deb_cnt[k] = CNT_W'(f);
                end else if (deb_cnt[k] != 0) begin
                    deb_cnt[k] = deb_cnt[k] - 1'b1;
                end else if (is_down[k]) begin
                    is_down[k] = 1'b0;
                    push_code(3 * k + 2);
                    n++;
                end
                hold_cnt[k] = '0;
                rep_cnt[k]  = '0;
            end
            return n;
        endfunction

        // Predict the outcome of one accepted input beat
        function void note_beat(logic [ACTION_W-1:0] act, logic [PINS_W-1:0] pins);
            t_key_outcome r;
            int           total;
            r     = '0;
            total = 0;
            case (act)
                ACT_SCAN: begin
                    for (int k = 0; k < KEYS; k++)
                        total += scan_key_lane(k, pins[k] ^ active_low[k]);
                end
                ACT_POP_MAIN:   r.code = pop_event(1'b0);
                ACT_POP_SECOND: r.code = pop_event(1'b1);
                default:        main_ptr = wr_ptr;
            endcase
            for (int k = 0; k < KEYS; k++) r.flags[k] = is_down[k];
            r.added = ADDED_W'(total);
            outcomes_due.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_beat(logic [CODE_W-1:0] code, logic [FLAG_W-1:0] flags,
                        logic [ADDED_W-1:0] added);
            t_key_outcome want;
            beats++;
            if (outcomes_due.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with no item pending", beats));
                return;
            end
            want = outcomes_due.pop_front();
            if (code !== want.code)
                report_mismatch($sformatf("beat %0d key_code %0d, expected %0d",
                                          beats, code, want.code));
            if (flags !== want.flags)
                report_mismatch($sformatf("beat %0d pressed_flags %b, expected %b",
                                          beats, flags, want.flags));
            if (added !== want.added)
                report_mismatch($sformatf("beat %0d events_added %0d, expected %0d",
                                          beats, added, want.added));
        endtask
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic [ACTION_W-1:0]   i_action        = ACT_SCAN;
    logic [PINS_W-1:0]     i_key_pins      = '0;
    logic                  i_out_stall     = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = REG_FILTER;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [CODE_W-1:0]     o_key_code;
    logic [FLAG_W-1:0]     o_pressed_flags;
    logic [ADDED_W-1:0]    o_events_added;

    bit                    calm = 1'b0;
    key_event_scoreboard   sb = new();

    key_debounce_event_fifo_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_key_pins      (i_key_pins),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_key_code      (o_key_code),
        .o_pressed_flags (o_pressed_flags),
        .o_events_added  (o_events_added),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at random, except during the calm stretch
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Score both channels on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_beat(i_action, i_key_pins);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_key_code, o_pressed_flags, o_events_added);
    end

    // Offer one beat, with random idle cycles ahead of it, and hold until taken
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [PINS_W-1:0] pins);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key_pins <= pins;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid, wait for every owed outcome, then let the block settle
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outcomes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_cfg(input logic [FILT_W-1:0] f, input logic [LONG_W-1:0] l,
                             input logic [SPEED_W-1:0] s, input logic [MASK_W-1:0] re,
                             input logic [MASK_W-1:0] al);
        write_reg(REG_FILTER,     CFG_DATA_W'(f));
        write_reg(REG_LONG,       CFG_DATA_W'(l));
        write_reg(REG_SPEED,      CFG_DATA_W'(s));
        write_reg(REG_REPEAT_EN,  CFG_DATA_W'(re));
        write_reg(REG_ACTIVE_LOW, CFG_DATA_W'(al));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [PINS_W-1:0] held;
        logic [PINS_W-1:0] pins;
        int                pick;
        int                bit_sel;
        held = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty readers, clear, pin extremes
        send_item(ACT_POP_MAIN, '0);
        send_item(ACT_POP_SECOND, '1);
        send_item(ACT_CLEAR, '0);
        send_item(ACT_SCAN, '1);
        send_item(ACT_SCAN, '0);
        send_item(ACT_SCAN, '1);
        drain_and_settle();

        // Zero filter time, long press after one tick: twelve codes in one tick,
        // then repeats and releases until the writer laps both readers
        write_cfg('0, LONG_W'(1), SPEED_W'(1), '1, '0);
        send_item(ACT_SCAN, '1);
        send_item(ACT_SCAN, '1);
        send_item(ACT_SCAN, '0);
        send_item(ACT_SCAN, '0);
        repeat (3) send_item(ACT_POP_MAIN, '1);
        repeat (3) send_item(ACT_POP_SECOND, '0);
        send_item(ACT_CLEAR, '1);
        send_item(ACT_POP_MAIN, '0);
        send_item(ACT_POP_SECOND, '1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_and_settle();
            case (ph)
                0: write_cfg(FILT_W'(2), LONG_W'(6), SPEED_W'(3), '1,
                             MASK_W'($urandom_range(0, 63)));
                // long press off, slow debounce so counters saturate high
                1: write_cfg('1, '0, '0, MASK_W'($urandom_range(0, 63)),
                             MASK_W'($urandom_range(0, 63)));
                // lowered threshold while keys are still held
                2: write_cfg(FILT_W'(3), LONG_W'(4), SPEED_W'(1),
                             MASK_W'($urandom_range(0, 63)), MASK_W'($urandom_range(0, 63)));
                3: write_cfg(FILT_W'(1), '1, '1, '1, '1);
                4: write_cfg('0, LONG_W'(2), SPEED_W'(2), MASK_W'($urandom_range(0, 63)), '0);
                default: write_cfg(FILT_W'($urandom_range(1, 8)), LONG_W'($urandom_range(1, 20)),
                                   SPEED_W'($urandom_range(0, 6)),
                                   MASK_W'($urandom_range(0, 63)),
                                   MASK_W'($urandom_range(0, 63)));
            endcase
            calm = (ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    // Keys change intent rarely; pins bounce and pick up noise
                    for (int k = 0; k < KEYS; k++)
                        if ($urandom_range(0, 99) < TOGGLE_PCT) held[k] = ~held[k];
                    pins = held ^ sb.active_low;
                    if ($urandom_range(0, 99) < 10) begin
                        bit_sel = $urandom_range(0, KEYS - 1);
                        pins[bit_sel] = ~pins[bit_sel];
                    end else if ($urandom_range(0, 99) < 3) begin
                        pins = PINS_W'($urandom);
                    end
                    send_item(ACT_SCAN, pins);
                end else if (pick < 86) begin
                    send_item(ACT_POP_MAIN, PINS_W'($urandom));
                end else if (pick < 97) begin
                    send_item(ACT_POP_SECOND, PINS_W'($urandom));
                end else begin
                    send_item(ACT_CLEAR, PINS_W'($urandom));
                end
            end
        end
        calm = 1'b0;
        drain_and_settle();

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
